@@ src/ddc_pkg.sv @@
// Shared types and constants for the door drive controller.
// Holds direction and action codes, register indexes and the item and result structs.
// Depends on nothing.
package ddc_pkg;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_OPEN  = 2'd1,
    DIR_CLOSE = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ACT_POLL      = 3'd0,
    ACT_INIT      = 3'd1,
    ACT_EXT_OPEN  = 3'd2,
    ACT_EXT_CLOSE = 3'd3,
    ACT_EXT_STOP  = 3'd4
  } action_t;

  localparam int unsigned SETTLE_W  = 16;
  localparam int unsigned MAX_RUN_W = 20;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 3;

  localparam logic [0:0] REG_CLOSED_SETTLE = 1'd0;
  localparam logic [0:0] REG_MAX_RUN       = 1'd1;

  localparam logic [SETTLE_W-1:0]  SETTLE_RESET  = 16'd1000;
  localparam logic [MAX_RUN_W-1:0] MAX_RUN_RESET = 20'd60000;

  typedef struct packed {
    logic [SETTLE_W-1:0]  closed_settle_ms;
    logic [MAX_RUN_W-1:0] max_run_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [TIME_W-1:0] now_ms;
    logic              button_level;
    logic              open_switch_hit;
    logic              closed_switch_hit;
    logic              is_daylight;
    logic              is_cold;
    logic              late_open_due;
  } item_t;

  typedef struct packed {
    dir_t motor_run;
    dir_t end_position;
    dir_t next_direction;
    logic fault_switch;
    logic fault_timeout;
  } result_t;

endpackage

@@ src/ddc_cfg.sv @@
// Configuration registers of the door drive controller behind an APB-style port.
// Holds the closed switch settle time and the maximum run time.
// Depends on ddc_pkg.
module ddc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ddc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ddc_pkg::DATA_W-1:0]  pwdata,
  output logic [ddc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ddc_pkg::cfg_t               cfg
);

  logic [ddc_pkg::SETTLE_W-1:0]  settle_r;
  logic [ddc_pkg::MAX_RUN_W-1:0] max_run_r;
  logic [0:0]                    reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r  <= ddc_pkg::SETTLE_RESET;
      max_run_r <= ddc_pkg::MAX_RUN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        ddc_pkg::REG_CLOSED_SETTLE: settle_r  <= pwdata[ddc_pkg::SETTLE_W-1:0];
        ddc_pkg::REG_MAX_RUN:       max_run_r <= pwdata[ddc_pkg::MAX_RUN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ddc_pkg::REG_CLOSED_SETTLE:
        prdata = {{(ddc_pkg::DATA_W-ddc_pkg::SETTLE_W){1'b0}}, settle_r};
      ddc_pkg::REG_MAX_RUN:
        prdata = {{(ddc_pkg::DATA_W-ddc_pkg::MAX_RUN_W){1'b0}}, max_run_r};
    endcase
  end

  assign cfg.closed_settle_ms = settle_r;
  assign cfg.max_run_ms       = max_run_r;

endmodule

@@ src/ddc_ctrl.sv @@
// Door control state and its update for one item, registered when the item fires.
// Qualifies the switches, tracks faults and decides the motor command.
// Depends on ddc_pkg.
module ddc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  ddc_pkg::item_t   item,
  input  ddc_pkg::cfg_t    cfg,
  output ddc_pkg::result_t res
);

  ddc_pkg::dir_t               run_dir_r, run_dir_nxt;
  ddc_pkg::dir_t               next_dir_r, next_dir_nxt;
  ddc_pkg::dir_t               pos_now_r, pos_now_nxt;
  ddc_pkg::dir_t               pos_saved_r, pos_saved_nxt;
  logic                        button_saved_r, button_saved_nxt;
  logic                        day_saved_r, day_saved_nxt;
  logic                        closed_seen_r, closed_seen_nxt;
  logic [ddc_pkg::TIME_W-1:0]  seen_time_r, seen_time_nxt;
  logic [ddc_pkg::TIME_W-1:0]  start_time_r, start_time_nxt;
  logic                        postponed_r, postponed_nxt;
  logic                        fault_sw_r, fault_sw_nxt;
  logic                        fault_to_r, fault_to_nxt;

  logic [ddc_pkg::TIME_W-1:0]  seen_elapsed;
  logic [ddc_pkg::TIME_W-1:0]  run_elapsed;
  logic                        settle_done;
  logic                        run_overdue;
  ddc_pkg::action_t            act;

  function automatic ddc_pkg::dir_t stop_next(input ddc_pkg::dir_t run);
    return (run == ddc_pkg::DIR_OPEN) ? ddc_pkg::DIR_CLOSE : ddc_pkg::DIR_OPEN;
  endfunction

  assign act          = ddc_pkg::action_t'(item.action);
  assign seen_elapsed = item.now_ms - seen_time_r;
  assign run_elapsed  = item.now_ms - start_time_r;
  // A switch first seen on this item has zero elapsed time and cannot qualify yet.
  assign settle_done  = closed_seen_r &&
      (seen_elapsed > {{(ddc_pkg::TIME_W-ddc_pkg::SETTLE_W){1'b0}}, cfg.closed_settle_ms});
  assign run_overdue  =
      (run_elapsed > {{(ddc_pkg::TIME_W-ddc_pkg::MAX_RUN_W){1'b0}}, cfg.max_run_ms});

  always_comb begin
    logic          done;
    ddc_pkg::dir_t pos;
    done             = 1'b0;
    pos              = ddc_pkg::DIR_NONE;
    run_dir_nxt      = run_dir_r;
    next_dir_nxt     = next_dir_r;
    pos_now_nxt      = pos_now_r;
    pos_saved_nxt    = pos_saved_r;
    button_saved_nxt = button_saved_r;
    day_saved_nxt    = day_saved_r;
    closed_seen_nxt  = closed_seen_r;
    seen_time_nxt    = seen_time_r;
    start_time_nxt   = start_time_r;
    postponed_nxt    = postponed_r;
    fault_sw_nxt     = fault_sw_r;
    fault_to_nxt     = fault_to_r;

    case (act)
      ddc_pkg::ACT_POLL: begin
        if (item.open_switch_hit && item.closed_switch_hit) begin
          fault_sw_nxt = 1'b1;
          next_dir_nxt = stop_next(run_dir_nxt);
          run_dir_nxt  = ddc_pkg::DIR_NONE;
          done         = 1'b1;
        end
        if (!done) begin
          if (item.open_switch_hit) begin
            pos = ddc_pkg::DIR_OPEN;
          end
          if (item.closed_switch_hit) begin
            if (!closed_seen_r) begin
              seen_time_nxt   = item.now_ms;
              closed_seen_nxt = 1'b1;
            end
            if (settle_done) begin
              pos = ddc_pkg::DIR_CLOSE;
            end
          end else begin
            closed_seen_nxt = 1'b0;
          end
          pos_now_nxt = pos;

          if (pos_saved_r != pos) begin
            pos_saved_nxt = pos;
            if (run_dir_nxt == ddc_pkg::DIR_NONE) begin
              fault_sw_nxt = 1'b1;
            end
            if (run_dir_nxt != pos && pos != ddc_pkg::DIR_NONE) begin
              fault_sw_nxt = 1'b1;
              next_dir_nxt = stop_next(run_dir_nxt);
              run_dir_nxt  = ddc_pkg::DIR_NONE;
            end
          end

          if (run_dir_nxt != ddc_pkg::DIR_NONE) begin
            if (run_overdue) begin
              fault_to_nxt = 1'b1;
              next_dir_nxt = stop_next(run_dir_nxt);
              run_dir_nxt  = ddc_pkg::DIR_NONE;
              done         = 1'b1;
            end else if (run_dir_nxt == pos) begin
              next_dir_nxt = stop_next(run_dir_nxt);
              run_dir_nxt  = ddc_pkg::DIR_NONE;
              done         = 1'b1;
            end
          end
        end

        if (!done && button_saved_r != item.button_level) begin
          button_saved_nxt = item.button_level;
          if (item.button_level) begin
            fault_sw_nxt = 1'b0;
            fault_to_nxt = 1'b0;
            if (run_dir_nxt != ddc_pkg::DIR_NONE) begin
              next_dir_nxt = stop_next(run_dir_nxt);
              run_dir_nxt  = ddc_pkg::DIR_NONE;
              done         = 1'b1;
            end else if (next_dir_nxt == ddc_pkg::DIR_OPEN ||
                         next_dir_nxt == ddc_pkg::DIR_CLOSE) begin
              run_dir_nxt    = next_dir_nxt;
              start_time_nxt = item.now_ms;
              done           = 1'b1;
            end
          end
        end

        if (!done && day_saved_r != item.is_daylight) begin
          day_saved_nxt = item.is_daylight;
          if (!item.is_daylight && pos != ddc_pkg::DIR_CLOSE) begin
            run_dir_nxt    = ddc_pkg::DIR_CLOSE;
            start_time_nxt = item.now_ms;
            done           = 1'b1;
          end else if (item.is_daylight && pos != ddc_pkg::DIR_OPEN) begin
            if (!item.is_cold) begin
              run_dir_nxt    = ddc_pkg::DIR_OPEN;
              start_time_nxt = item.now_ms;
              done           = 1'b1;
            end else begin
              postponed_nxt = 1'b1;
            end
          end
        end

        if (!done && day_saved_nxt && pos != ddc_pkg::DIR_OPEN && postponed_nxt &&
            item.late_open_due) begin
          postponed_nxt  = 1'b0;
          run_dir_nxt    = ddc_pkg::DIR_OPEN;
          start_time_nxt = item.now_ms;
        end
      end

      ddc_pkg::ACT_INIT: begin
        run_dir_nxt   = ddc_pkg::DIR_NONE;
        day_saved_nxt = item.is_daylight;
        pos_saved_nxt = ddc_pkg::DIR_NONE;
        next_dir_nxt  = ddc_pkg::DIR_CLOSE;
        if (item.open_switch_hit) begin
          pos_saved_nxt = ddc_pkg::DIR_OPEN;
          next_dir_nxt  = ddc_pkg::DIR_CLOSE;
        end
        if (item.closed_switch_hit) begin
          pos_saved_nxt   = ddc_pkg::DIR_CLOSE;
          next_dir_nxt    = ddc_pkg::DIR_OPEN;
          closed_seen_nxt = 1'b1;
          seen_time_nxt   = item.now_ms -
              {{(ddc_pkg::TIME_W-ddc_pkg::SETTLE_W){1'b0}}, cfg.closed_settle_ms};
        end
      end

      ddc_pkg::ACT_EXT_OPEN: begin
        fault_sw_nxt   = 1'b0;
        fault_to_nxt   = 1'b0;
        run_dir_nxt    = ddc_pkg::DIR_OPEN;
        start_time_nxt = item.now_ms;
      end

      ddc_pkg::ACT_EXT_CLOSE: begin
        fault_sw_nxt   = 1'b0;
        fault_to_nxt   = 1'b0;
        run_dir_nxt    = ddc_pkg::DIR_CLOSE;
        start_time_nxt = item.now_ms;
      end

      ddc_pkg::ACT_EXT_STOP: begin
        fault_sw_nxt = 1'b0;
        fault_to_nxt = 1'b0;
        next_dir_nxt = stop_next(run_dir_r);
        run_dir_nxt  = ddc_pkg::DIR_NONE;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_dir_r      <= ddc_pkg::DIR_NONE;
      next_dir_r     <= ddc_pkg::DIR_CLOSE;
      pos_now_r      <= ddc_pkg::DIR_NONE;
      pos_saved_r    <= ddc_pkg::DIR_NONE;
      button_saved_r <= 1'b0;
      day_saved_r    <= 1'b0;
      closed_seen_r  <= 1'b0;
      seen_time_r    <= '0;
      start_time_r   <= '0;
      postponed_r    <= 1'b0;
      fault_sw_r     <= 1'b0;
      fault_to_r     <= 1'b0;
    end else if (fire) begin
      run_dir_r      <= run_dir_nxt;
      next_dir_r     <= next_dir_nxt;
      pos_now_r      <= pos_now_nxt;
      pos_saved_r    <= pos_saved_nxt;
      button_saved_r <= button_saved_nxt;
      day_saved_r    <= day_saved_nxt;
      closed_seen_r  <= closed_seen_nxt;
      seen_time_r    <= seen_time_nxt;
      start_time_r   <= start_time_nxt;
      postponed_r    <= postponed_nxt;
      fault_sw_r     <= fault_sw_nxt;
      fault_to_r     <= fault_to_nxt;
    end
  end

  assign res.motor_run      = run_dir_nxt;
  assign res.end_position   = pos_now_nxt;
  assign res.next_direction = next_dir_nxt;
  assign res.fault_switch   = fault_sw_nxt;
  assign res.fault_timeout  = fault_to_nxt;

endmodule

@@ src/door_drive_controller.sv @@
// Top level of the door drive controller: input register, control update, result register.
// Depends on ddc_pkg, ddc_cfg and ddc_ctrl.
//
// Each item on the input channel yields exactly one result item, the controller state after
// that item. The block takes one item per clock cycle while the result channel does not
// stall. The control update works on the input register, and the result register takes the
// result at the same edge as the state registers take the new state. When the result channel
// stalls, the result register holds, the input register fills and then the input channel
// stalls. After reset the settle time is 1000 ms and the maximum run time 60000 ms; write
// them through the APB port only while no item is in flight.
module door_drive_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_action,
  input  logic [31:0]                 in_now_ms,
  input  logic                        in_button_level,
  input  logic                        in_open_switch_hit,
  input  logic                        in_closed_switch_hit,
  input  logic                        in_is_daylight,
  input  logic                        in_is_cold,
  input  logic                        in_late_open_due,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_motor_run,
  output logic [1:0]                  out_end_position,
  output logic [1:0]                  out_next_direction,
  output logic                        out_fault_switch,
  output logic                        out_fault_timeout,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ddc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ddc_pkg::DATA_W-1:0]  pwdata,
  output logic [ddc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic             in_v_r;
  ddc_pkg::item_t   in_item_r;
  logic             out_v_r;
  ddc_pkg::result_t out_res_r;
  logic             fire;
  logic             in_take;
  ddc_pkg::cfg_t    cfg;
  ddc_pkg::result_t res;

  assign fire     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.action            <= in_action;
      in_item_r.now_ms            <= in_now_ms;
      in_item_r.button_level      <= in_button_level;
      in_item_r.open_switch_hit   <= in_open_switch_hit;
      in_item_r.closed_switch_hit <= in_closed_switch_hit;
      in_item_r.is_daylight       <= in_is_daylight;
      in_item_r.is_cold           <= in_is_cold;
      in_item_r.late_open_due     <= in_late_open_due;
    end
  end

  ddc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ddc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_motor_run      = out_res_r.motor_run;
  assign out_end_position   = out_res_r.end_position;
  assign out_next_direction = out_res_r.next_direction;
  assign out_fault_switch   = out_res_r.fault_switch;
  assign out_fault_timeout  = out_res_r.fault_timeout;

endmodule

@@ test/tb_door_drive_controller.sv @@
// Testbench for door_drive_controller: drives polls and commands from a simple door travel
// model, predicts the state report of every item and checks it field by field.
// Depends on ddc_pkg and the door_drive_controller RTL.
module tb_door_drive_controller;

  localparam logic [2:0] ACT_RESERVED_A = 3'd5;
  localparam logic [2:0] ACT_RESERVED_B = 3'd6;
  localparam logic [2:0] ACT_RESERVED_C = 3'd7;
  localparam logic [ddc_pkg::ADDR_W-1:0] ADDR_SETTLE  =
      ddc_pkg::ADDR_W'(4 * ddc_pkg::REG_CLOSED_SETTLE);
  localparam logic [ddc_pkg::ADDR_W-1:0] ADDR_MAX_RUN =
      ddc_pkg::ADDR_W'(4 * ddc_pkg::REG_MAX_RUN);
  localparam int TRAVEL = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_action = '0;
  logic [31:0] in_now_ms = '0;
  logic in_button_level = 1'b0;
  logic in_open_switch_hit = 1'b0;
  logic in_closed_switch_hit = 1'b0;
  logic in_is_daylight = 1'b0;
  logic in_is_cold = 1'b0;
  logic in_late_open_due = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_motor_run;
  logic [1:0] out_end_position;
  logic [1:0] out_next_direction;
  logic out_fault_switch;
  logic out_fault_timeout;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ddc_pkg::ADDR_W-1:0] paddr = '0;
  logic [ddc_pkg::DATA_W-1:0] pwdata = '0;
  logic [ddc_pkg::DATA_W-1:0] prdata;
  logic pready;

  door_drive_controller DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_now_ms(in_now_ms), .in_button_level(in_button_level),
    .in_open_switch_hit(in_open_switch_hit), .in_closed_switch_hit(in_closed_switch_hit),
    .in_is_daylight(in_is_daylight), .in_is_cold(in_is_cold),
    .in_late_open_due(in_late_open_due),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_motor_run(out_motor_run), .out_end_position(out_end_position),
    .out_next_direction(out_next_direction), .out_fault_switch(out_fault_switch),
    .out_fault_timeout(out_fault_timeout),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predicted controller state and register copies.
  ddc_pkg::dir_t st_run, st_next, st_pos, st_pos_prev;
  logic st_button, st_day, st_closed_seen, st_postponed, st_fault_sw, st_fault_to;
  logic [31:0] st_closed_t, st_run_t;
  logic [ddc_pkg::SETTLE_W-1:0] settle_ms;
  logic [ddc_pkg::MAX_RUN_W-1:0] max_run_ms;

  ddc_pkg::result_t pending_reports [$];
  int error_count = 0;
  int reports_checked = 0;
  int items_sent = 0;
  int settings_written = 0;
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  int rx_hold = 0;

  // Stimulus side of the door: travel position, wall clock and operator inputs.
  int door_travel = 0;
  logic [31:0] wall_ms = 32'd2000;
  logic button_held = 1'b0;
  logic daylight = 1'b0;

  function automatic void reset_model();
    settle_ms = ddc_pkg::SETTLE_RESET;
    max_run_ms = ddc_pkg::MAX_RUN_RESET;
    st_run = ddc_pkg::DIR_NONE;
    st_next = ddc_pkg::DIR_CLOSE;
    st_pos = ddc_pkg::DIR_NONE;
    st_pos_prev = ddc_pkg::DIR_NONE;
    st_button = 1'b0;
    st_day = 1'b0;
    st_closed_seen = 1'b0;
    st_closed_t = '0;
    st_run_t = '0;
    st_postponed = 1'b0;
    st_fault_sw = 1'b0;
    st_fault_to = 1'b0;
  endfunction

  function automatic void motor_halt();
    if (st_run == ddc_pkg::DIR_OPEN) begin
      st_next = ddc_pkg::DIR_CLOSE;
    end else begin
      st_next = ddc_pkg::DIR_OPEN;
    end
    st_run = ddc_pkg::DIR_NONE;
  endfunction

  function automatic void motor_go(input ddc_pkg::dir_t dir, input logic [31:0] now);
    st_run = dir;
    st_run_t = now;
  endfunction

  function automatic void door_poll(input ddc_pkg::item_t it);
    logic [31:0] held;
    logic [31:0] running;
    if (it.open_switch_hit && it.closed_switch_hit) begin
      st_fault_sw = 1'b1;
      motor_halt();
      return;
    end
    st_pos = ddc_pkg::DIR_NONE;
    if (it.open_switch_hit) st_pos = ddc_pkg::DIR_OPEN;
    if (it.closed_switch_hit) begin
      if (!st_closed_seen) begin
        st_closed_t = it.now_ms;
        st_closed_seen = 1'b1;
      end
      held = it.now_ms - st_closed_t;
      if (held > {16'd0, settle_ms}) st_pos = ddc_pkg::DIR_CLOSE;
    end else begin
      st_closed_seen = 1'b0;
    end
    if (st_pos_prev != st_pos) begin
      st_pos_prev = st_pos;
      if (st_run == ddc_pkg::DIR_NONE) st_fault_sw = 1'b1;
      if (st_run != st_pos && st_pos != ddc_pkg::DIR_NONE) begin
        st_fault_sw = 1'b1;
        motor_halt();
      end
    end
    if (st_run != ddc_pkg::DIR_NONE) begin
      running = it.now_ms - st_run_t;
      if (running > {12'd0, max_run_ms}) begin
        st_fault_to = 1'b1;
        motor_halt();
        return;
      end
      if (st_run == st_pos) begin
        motor_halt();
        return;
      end
    end
    if (st_button != it.button_level) begin
      st_button = it.button_level;
      if (it.button_level) begin
        st_fault_sw = 1'b0;
        st_fault_to = 1'b0;
        if (st_run != ddc_pkg::DIR_NONE) begin
          motor_halt();
          return;
        end
        if (st_next == ddc_pkg::DIR_OPEN) begin
          motor_go(ddc_pkg::DIR_OPEN, it.now_ms);
          return;
        end
        if (st_next == ddc_pkg::DIR_CLOSE) begin
          motor_go(ddc_pkg::DIR_CLOSE, it.now_ms);
          return;
        end
      end
    end
    if (st_day != it.is_daylight) begin
      st_day = it.is_daylight;
      if (!it.is_daylight && st_pos != ddc_pkg::DIR_CLOSE) begin
        motor_go(ddc_pkg::DIR_CLOSE, it.now_ms);
        return;
      end
      if (it.is_daylight && st_pos != ddc_pkg::DIR_OPEN) begin
        if (!it.is_cold) begin
          motor_go(ddc_pkg::DIR_OPEN, it.now_ms);
          return;
        end
        st_postponed = 1'b1;
      end
    end
    if (st_day && st_pos != ddc_pkg::DIR_OPEN && st_postponed && it.late_open_due) begin
      st_postponed = 1'b0;
      motor_go(ddc_pkg::DIR_OPEN, it.now_ms);
    end
  endfunction

  function automatic void door_init(input ddc_pkg::item_t it);
    motor_halt();
    st_day = it.is_daylight;
    st_pos_prev = ddc_pkg::DIR_NONE;
    st_next = ddc_pkg::DIR_CLOSE;
    if (it.open_switch_hit) begin
      st_pos_prev = ddc_pkg::DIR_OPEN;
      st_next = ddc_pkg::DIR_CLOSE;
    end
    if (it.closed_switch_hit) begin
      st_pos_prev = ddc_pkg::DIR_CLOSE;
      st_next = ddc_pkg::DIR_OPEN;
      st_closed_seen = 1'b1;
      st_closed_t = it.now_ms - {16'd0, settle_ms};
    end
  endfunction

  function automatic ddc_pkg::result_t door_update(input ddc_pkg::item_t it);
    ddc_pkg::result_t r;
    case (it.action)
      ddc_pkg::ACT_POLL: door_poll(it);
      ddc_pkg::ACT_INIT: door_init(it);
      ddc_pkg::ACT_EXT_OPEN: begin
        st_fault_sw = 1'b0;
        st_fault_to = 1'b0;
        motor_go(ddc_pkg::DIR_OPEN, it.now_ms);
      end
      ddc_pkg::ACT_EXT_CLOSE: begin
        st_fault_sw = 1'b0;
        st_fault_to = 1'b0;
        motor_go(ddc_pkg::DIR_CLOSE, it.now_ms);
      end
      ddc_pkg::ACT_EXT_STOP: begin
        st_fault_sw = 1'b0;
        st_fault_to = 1'b0;
        motor_halt();
      end
      default: ;
    endcase
    r.motor_run = st_run;
    r.end_position = st_pos;
    r.next_direction = st_next;
    r.fault_switch = st_fault_sw;
    r.fault_timeout = st_fault_to;
    return r;
  endfunction

  function automatic ddc_pkg::item_t make_item(input logic [2:0] action,
                                               input logic [31:0] now,
                                               input bit button, input bit open_hit,
                                               input bit closed_hit, input bit day,
                                               input bit cold, input bit late);
    ddc_pkg::item_t it;
    it.action = action;
    it.now_ms = now;
    it.button_level = button;
    it.open_switch_hit = open_hit;
    it.closed_switch_hit = closed_hit;
    it.is_daylight = day;
    it.is_cold = cold;
    it.late_open_due = late;
    return it;
  endfunction

  function automatic ddc_pkg::item_t random_item();
    ddc_pkg::item_t it;
    it.action = 3'($urandom_range(ddc_pkg::ACT_POLL, ACT_RESERVED_C));
    it.now_ms = ($urandom_range(0, 3) == 0) ? $urandom() : wall_ms;
    it.button_level = 1'($urandom_range(0, 1));
    it.open_switch_hit = 1'($urandom_range(0, 1));
    it.closed_switch_hit = 1'($urandom_range(0, 1));
    it.is_daylight = 1'($urandom_range(0, 1));
    it.is_cold = 1'($urandom_range(0, 1));
    it.late_open_due = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_item(input ddc_pkg::item_t it);
    int gap;
    logic stalled;
    gap = tx_idling ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= it.action;
    in_now_ms <= it.now_ms;
    in_button_level <= it.button_level;
    in_open_switch_hit <= it.open_switch_hit;
    in_closed_switch_hit <= it.closed_switch_hit;
    in_is_daylight <= it.is_daylight;
    in_is_cold <= it.is_cold;
    in_late_open_due <= it.late_open_due;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    pending_reports.push_back(door_update(it));
    items_sent++;
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ddc_pkg::ADDR_W-1:0] addr,
                           input logic [ddc_pkg::DATA_W-1:0] data);
    logic ready;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [ddc_pkg::ADDR_W-1:0] addr,
                          output logic [ddc_pkg::DATA_W-1:0] data);
    logic ready;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      data = prdata;
      @(posedge clk);
    end while (!ready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [ddc_pkg::SETTLE_W-1:0] settle,
                               input logic [ddc_pkg::MAX_RUN_W-1:0] max_run);
    logic [ddc_pkg::DATA_W-1:0] readback;
    apb_write(ADDR_SETTLE, ddc_pkg::DATA_W'(settle));
    apb_write(ADDR_MAX_RUN, ddc_pkg::DATA_W'(max_run));
    settle_ms = settle;
    max_run_ms = max_run;
    settings_written++;
    apb_read(ADDR_SETTLE, readback);
    if (readback !== ddc_pkg::DATA_W'(settle)) begin
      error_count++;
      $display("%0t: closed_settle_ms read expected %0d actual %0d", $time, settle, readback);
    end
    apb_read(ADDR_MAX_RUN, readback);
    if (readback !== ddc_pkg::DATA_W'(max_run)) begin
      error_count++;
      $display("%0t: max_run_ms read expected %0d actual %0d", $time, max_run, readback);
    end
  endtask

  // Polls follow the door as the predicted motor moves it, with some commands and glitches.
  task automatic door_traffic(input int count, input int noise_pct, input bit vary_idle);
    ddc_pkg::item_t it;
    int pick;
    int k;
    for (k = 0; k < count; k++) begin
      if (vary_idle && k % 48 == 0) begin
        tx_idling = ($urandom_range(0, 3) != 0);
        rx_idling = ($urandom_range(0, 3) != 0);
      end
      if (st_run == ddc_pkg::DIR_OPEN && door_travel < TRAVEL) begin
        door_travel++;
      end else if (st_run == ddc_pkg::DIR_CLOSE && door_travel > 0) begin
        door_travel--;
      end
      wall_ms = wall_ms + $urandom_range(1, 400);
      if ($urandom_range(0, 39) == 0) wall_ms = wall_ms + $urandom_range(0, 70000);
      if ($urandom_range(0, 15) == 0) button_held = ~button_held;
      if ($urandom_range(0, 47) == 0) daylight = ~daylight;
      it = make_item(ddc_pkg::ACT_POLL, wall_ms, button_held, door_travel == TRAVEL,
                     door_travel == 0, daylight, 1'($urandom_range(0, 1)),
                     $urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < noise_pct) begin
        it = random_item();
      end else if (pick < noise_pct + 3) begin
        it.action = 3'($urandom_range(ddc_pkg::ACT_INIT, ddc_pkg::ACT_EXT_STOP));
      end else if (pick < noise_pct + 4) begin
        it.open_switch_hit = 1'b1;
        it.closed_switch_hit = 1'b1;
      end
      send_item(it);
    end
  endtask

  task automatic test_directed();
    ddc_pkg::item_t seq [$];
    seq.push_back(make_item(ddc_pkg::ACT_INIT, 32'd0, 0, 0, 1, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'd1, 0, 0, 1, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'd100, 1, 0, 1, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'd200, 0, 0, 0, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'd300, 0, 1, 0, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'd400, 0, 1, 1, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'd500, 1, 1, 0, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'd600, 0, 1, 0, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_EXT_CLOSE, 32'd700, 0, 0, 0, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_EXT_STOP, 32'd800, 0, 0, 0, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_EXT_OPEN, 32'd900, 0, 0, 0, 0, 0, 0));
    seq.push_back(make_item(ACT_RESERVED_A, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1));
    seq.push_back(make_item(ACT_RESERVED_B, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1));
    seq.push_back(make_item(ACT_RESERVED_C, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'h10, 0, 0, 0, 1, 1, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'h20, 0, 0, 0, 1, 1, 1));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'h30, 0, 0, 0, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_EXT_STOP, 32'h40, 0, 0, 0, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'd100, 0, 0, 1, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'd1100, 0, 0, 1, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_POLL, 32'd1101, 0, 0, 1, 0, 0, 0));
    seq.push_back(make_item(ddc_pkg::ACT_INIT, 32'd1200, 1, 1, 1, 1, 1, 1));
    foreach (seq[i]) send_item(seq[i]);
    drain_reports();
  endtask

  task automatic test_register_sweep();
    logic [ddc_pkg::SETTLE_W-1:0] settles [5];
    logic [ddc_pkg::MAX_RUN_W-1:0] runs [5];
    settles = '{16'd0, 16'hFFFF, 16'd1, 16'd300, ddc_pkg::SETTLE_RESET};
    runs = '{20'd0, 20'hF_FFFF, 20'd2500, 20'd20000, ddc_pkg::MAX_RUN_RESET};
    foreach (settles[i]) begin
      set_registers(settles[i], runs[i]);
      door_traffic(220, 5, 1'b1);
      drain_reports();
    end
  endtask

  task automatic test_time_wrap();
    wall_ms = 32'hFFFF_F800;
    door_traffic(150, 5, 1'b1);
    drain_reports();
  endtask

  task automatic test_backpressure();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    rx_hold = 300;
    door_traffic(40, 5, 1'b0);
    drain_reports();
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    door_traffic(100, 5, 1'b1);
    drain_reports();
  endtask

  task automatic test_noise();
    door_traffic(250, 60, 1'b1);
    drain_reports();
  endtask

  function automatic void compare_field(input string what, input logic [1:0] want,
                                        input logic [1:0] seen);
    if (seen !== want) begin
      error_count++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, seen);
    end
  endfunction

  task automatic check_report(input ddc_pkg::result_t got);
    ddc_pkg::result_t want;
    if (pending_reports.size() == 0) begin
      error_count++;
      $display("%0t: report expected none actual %h", $time, got);
      return;
    end
    want = pending_reports.pop_front();
    reports_checked++;
    compare_field("motor_run", want.motor_run, got.motor_run);
    compare_field("end_position", want.end_position, got.end_position);
    compare_field("next_direction", want.next_direction, got.next_direction);
    compare_field("fault_switch", want.fault_switch, got.fault_switch);
    compare_field("fault_timeout", want.fault_timeout, got.fault_timeout);
  endtask

  initial begin : report_side
    ddc_pkg::result_t got;
    logic took;
    int rx_wait;
    rx_wait = 0;
    forever begin
      @(negedge clk);
      took = rst_n && out_valid && !out_stall;
      got = {out_motor_run, out_end_position, out_next_direction,
             out_fault_switch, out_fault_timeout};
      @(posedge clk);
      if (took === 1'b1) begin
        check_report(got);
        rx_wait = rx_idling ? $urandom_range(0, 11) : 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : run_tests
    int guard;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_sweep();
    test_time_wrap();
    test_backpressure();
    test_noise();
    guard = 0;
    while (pending_reports.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (pending_reports.size() != 0) begin
      error_count += pending_reports.size();
      $display("%0t: reports expected %0d more actual 0", $time, pending_reports.size());
    end
    $display("Sent %0d polls and commands, checked %0d state reports over %0d register settings,",
             items_sent, reports_checked, settings_written);
    $display("with random idling, a long output hold-off and a time base wrapping past zero.");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Run did not finish in time.");
    $display("status: fail");
    $finish;
  end

endmodule

@@ door_drive_controller.f @@
src/ddc_pkg.sv
src/ddc_cfg.sv
src/ddc_ctrl.sv
src/door_drive_controller.sv
test/tb_door_drive_controller.sv
